// File: hw/rtl/gro_pkg.sv
// Shared types and constants of the grid region occupancy unit.
package gro_pkg;

  localparam int unsigned ANCHOR_W    = 5;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned OWNER_IN_W  = 8;
  localparam int unsigned OWNER_OUT_W = 8;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_DONE
  } state_e;

endpackage

// File: hw/rtl/gro_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gro_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gro_row_unit.sv
// Row unit: tests, merges and selects the cells of one grid row.
module gro_row_unit
  import gro_pkg::*;
#(
  parameter int unsigned GRID_SIZE  = 32,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic [GRID_SIZE*(OWNER_BITS+2*ANCHOR_W)-1:0] row_i,
  input  logic                                         row_valid_i,
  input  logic [((($clog2(GRID_SIZE) > SIZE_W) ? $clog2(GRID_SIZE) : SIZE_W) + 1)-1:0] y_lo_i,
  input  logic [((($clog2(GRID_SIZE) > SIZE_W) ? $clog2(GRID_SIZE) : SIZE_W) + 1)-1:0] y_hi_i,
  input  logic                                         first_row_i,
  input  logic [OWNER_BITS-1:0]                        owner_i,
  input  logic [ANCHOR_W-1:0]                          anchor_x_i,
  input  logic [ANCHOR_W-1:0]                          anchor_y_i,
  input  logic [$clog2(GRID_SIZE)-1:0]                 sel_y_i,
  output logic                                         busy_o,
  output logic [GRID_SIZE*(OWNER_BITS+2*ANCHOR_W)-1:0] row_o,
  output logic [OWNER_BITS-1:0]                        cell_owner_o,
  output logic [ANCHOR_W-1:0]                          cell_anchor_x_o,
  output logic [ANCHOR_W-1:0]                          cell_anchor_y_o
);

  localparam int unsigned IDX_W  = $clog2(GRID_SIZE);
  localparam int unsigned SW     = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;
  localparam int unsigned CELL_W = OWNER_BITS + 2 * ANCHOR_W;

  logic [GRID_SIZE*CELL_W-1:0] base;
  logic [GRID_SIZE-1:0]        in_rect;
  logic [GRID_SIZE-1:0]        taken;
  logic [CELL_W-1:0]           sel_cell;

  assign base = row_valid_i ? row_i : '0;

  always_comb begin
    row_o = base;
    for (int y = 0; y < GRID_SIZE; y++) begin
      in_rect[y] = (SW'(y) >= y_lo_i) && (SW'(y) < y_hi_i);
      taken[y]   = in_rect[y] &&
                   (base[y*CELL_W+2*ANCHOR_W +: OWNER_BITS] != '0);
      if (in_rect[y]) begin
        row_o[y*CELL_W+2*ANCHOR_W +: OWNER_BITS] = owner_i;
        if (!(first_row_i && (SW'(y) == y_lo_i))) begin
          row_o[y*CELL_W +: 2*ANCHOR_W] = {anchor_x_i, anchor_y_i};
        end
      end
    end
  end

  assign busy_o          = |taken;
  assign sel_cell        = base[sel_y_i*CELL_W +: CELL_W];
  assign cell_owner_o    = sel_cell[2*ANCHOR_W +: OWNER_BITS];
  assign cell_anchor_x_o = sel_cell[ANCHOR_W +: ANCHOR_W];
  assign cell_anchor_y_o = sel_cell[0 +: ANCHOR_W];

endmodule

// File: hw/rtl/grid_region_occupancy_unit.sv
// Top level of the grid region occupancy unit.
// The unit keeps a square grid of cell owners with an anchor pair per cell.
// Each input transfer carries one action: check a rectangle for being clear,
// fill a rectangle with an owner, or read one cell. Each action gives exactly
// one output transfer. The grid is held one column of cells per memory word,
// and a small sequencer walks the columns that the rectangle covers.
// A fill, or a check that finds its rectangle clear, reads and evaluates each
// column it covers inside the grid and then finishes in the done state, which
// moves the result into the output register.
// A check that meets an occupied column stops there; a read visits its one
// column, and an action that touches no column goes from the issue state
// straight to the done state. Each column is read in the issue state and
// evaluated in the eval state, as the memory read data is registered. Input
// stall is high from acceptance until the result has moved into the output
// register, and the next input transfer can be taken once it has. A finished
// result waits in that register while the receiver stalls, and the next input
// transfer is taken meanwhile. Reset marks every column invalid in flip-flops,
// so the grid reads as empty with zero anchors at once and no clearing pass is needed.
module grid_region_occupancy_unit
  import gro_pkg::*;
#(
  parameter int unsigned GRID_SIZE  = 32,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [POS_W-1:0]       pos_x_i,
  input  logic [POS_W-1:0]       pos_y_i,
  input  logic [SIZE_W-1:0]      rect_width_i,
  input  logic [SIZE_W-1:0]      rect_height_i,
  input  logic [OWNER_IN_W-1:0]  owner_id_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_clear_o,
  output logic [OWNER_OUT_W-1:0] cell_owner_o,
  output logic [ANCHOR_W-1:0]    cell_anchor_x_o,
  output logic [ANCHOR_W-1:0]    cell_anchor_y_o
);

  localparam int unsigned IDX_W  = $clog2(GRID_SIZE);
  localparam int unsigned SW     = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;
  localparam int unsigned CELL_W = OWNER_BITS + 2 * ANCHOR_W;
  localparam int unsigned ROW_W  = GRID_SIZE * CELL_W;
  localparam logic [SW-1:0] GRID_S = SW'(GRID_SIZE);

  state_e  state_q, state_d;
  action_e act_q, act_d;

  logic [SW-1:0]         cur_x_q, cur_x_d;
  logic [SW-1:0]         end_x_q, end_x_d;
  logic [SW-1:0]         x0_q, x0_d;
  logic [SW-1:0]         y0_q, y0_d;
  logic [SW-1:0]         y_end_q, y_end_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic                  clear_q, clear_d;
  logic [OWNER_BITS-1:0] rd_owner_q, rd_owner_d;
  logic [ANCHOR_W-1:0]   rd_ax_q, rd_ax_d;
  logic [ANCHOR_W-1:0]   rd_ay_q, rd_ay_d;

  logic [GRID_SIZE-1:0] row_valid_q, row_valid_d;
  logic                 rd_valid_q, rd_valid_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_clear_q, out_clear_d;
  logic [OWNER_OUT_W-1:0] out_owner_q, out_owner_d;
  logic [ANCHOR_W-1:0]    out_ax_q, out_ax_d;
  logic [ANCHOR_W-1:0]    out_ay_q, out_ay_d;

  logic                  accept;
  logic                  ram_re;
  logic                  ram_we;
  logic [IDX_W-1:0]      row_addr;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row_merged;
  logic                  row_busy;
  logic [OWNER_BITS-1:0] cell_owner;
  logic [ANCHOR_W-1:0]   cell_ax;
  logic [ANCHOR_W-1:0]   cell_ay;
  logic [SW-1:0]         px_s;
  logic [SW-1:0]         py_s;
  logic [SW-1:0]         x_sum;
  logic [SW-1:0]         y_sum;

  assign row_addr = cur_x_q[IDX_W-1:0];
  assign accept   = in_valid_i && !in_stall_o;
  assign px_s     = SW'(pos_x_i);
  assign py_s     = SW'(pos_y_i);
  assign x_sum    = px_s + SW'(rect_width_i);
  assign y_sum    = py_s + SW'(rect_height_i);

  gro_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GRID_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_addr),
    .wdata_i (row_merged),
    .re_i    (ram_re),
    .raddr_i (row_addr),
    .rdata_o (ram_rdata)
  );

  gro_row_unit #(
    .GRID_SIZE  (GRID_SIZE),
    .OWNER_BITS (OWNER_BITS)
  ) u_row_unit (
    .row_i           (ram_rdata),
    .row_valid_i     (rd_valid_q),
    .y_lo_i          (y0_q),
    .y_hi_i          (y_end_q),
    .first_row_i     (cur_x_q == x0_q),
    .owner_i         (owner_q),
    .anchor_x_i      (ANCHOR_W'(x0_q)),
    .anchor_y_i      (ANCHOR_W'(y0_q)),
    .sel_y_i         (IDX_W'(y0_q)),
    .busy_o          (row_busy),
    .row_o           (row_merged),
    .cell_owner_o    (cell_owner),
    .cell_anchor_x_o (cell_ax),
    .cell_anchor_y_o (cell_ay)
  );

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cur_x_d     = cur_x_q;
    end_x_d     = end_x_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    y_end_d     = y_end_q;
    owner_d     = owner_q;
    clear_d     = clear_q;
    rd_owner_d  = rd_owner_q;
    rd_ax_d     = rd_ax_q;
    rd_ay_d     = rd_ay_q;
    row_valid_d = row_valid_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_clear_d = out_clear_q;
    out_owner_d = out_owner_q;
    out_ax_d    = out_ax_q;
    out_ay_d    = out_ay_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d      = action_e'(action_i);
          cur_x_d    = px_s;
          x0_d       = px_s;
          y0_d       = py_s;
          y_end_d    = y_sum;
          owner_d    = OWNER_BITS'(owner_id_i);
          clear_d    = 1'b0;
          rd_owner_d = '0;
          rd_ax_d    = '0;
          rd_ay_d    = '0;
          end_x_d    = px_s;
          case (action_e'(action_i))
            ACT_CHECK: begin
              if ((x_sum <= GRID_S) && (y_sum <= GRID_S)) begin
                clear_d = 1'b1;
                end_x_d = x_sum;
              end
            end
            ACT_FILL: begin
              end_x_d = (x_sum > GRID_S) ? GRID_S : x_sum;
            end
            ACT_READ: begin
              if ((px_s < GRID_S) && (py_s < GRID_S)) begin
                end_x_d = px_s + SW'(1);
              end
            end
            default: begin
              end_x_d = px_s;
            end
          endcase
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (cur_x_q < end_x_q) begin
          ram_re     = 1'b1;
          rd_valid_d = row_valid_q[row_addr];
          state_d    = ST_EVAL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EVAL: begin
        cur_x_d = cur_x_q + SW'(1);
        state_d = ST_ISSUE;
        case (act_q)
          ACT_CHECK: begin
            if (row_busy) begin
              clear_d = 1'b0;
              state_d = ST_DONE;
            end
          end
          ACT_FILL: begin
            ram_we                = 1'b1;
            row_valid_d[row_addr] = 1'b1;
          end
          ACT_READ: begin
            rd_owner_d = cell_owner;
            rd_ax_d    = cell_ax;
            rd_ay_d    = cell_ay;
            state_d    = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_clear_d = clear_q;
          out_owner_d = OWNER_OUT_W'(rd_owner_q);
          out_ax_d    = rd_ax_q;
          out_ay_d    = rd_ay_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    cur_x_q     <= cur_x_d;
    end_x_q     <= end_x_d;
    x0_q        <= x0_d;
    y0_q        <= y0_d;
    y_end_q     <= y_end_d;
    owner_q     <= owner_d;
    clear_q     <= clear_d;
    rd_owner_q  <= rd_owner_d;
    rd_ax_q     <= rd_ax_d;
    rd_ay_q     <= rd_ay_d;
    rd_valid_q  <= rd_valid_d;
    out_clear_q <= out_clear_d;
    out_owner_q <= out_owner_d;
    out_ax_q    <= out_ax_d;
    out_ay_q    <= out_ay_d;
  end

  assign out_valid_o     = out_valid_q;
  assign is_clear_o      = out_clear_q;
  assign cell_owner_o    = out_owner_q;
  assign cell_anchor_x_o = out_ax_q;
  assign cell_anchor_y_o = out_ay_q;

endmodule
